// ----- design/sfdt_pkg.sv -----
// Shared constants, types and saturation helper for the stereo feedback delay.
`default_nettype none

package sfdt_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int LINE_DEPTH   = 262144;
   localparam int ADDR_BITS    = $clog2(LINE_DEPTH);
   localparam int LP_BITS      = 32;
   localparam int LP_FRAC      = LP_BITS - SAMPLE_BITS;
   localparam int COEF_BITS    = 16;
   localparam int FB_BITS      = 15;
   localparam int DELAY_BITS   = 18;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = DELAY_BITS;
   localparam int FB_MAX       = 31130;
   localparam int UNITY        = 32768;
   // headroom for sums that get clamped back to a sample
   localparam int SAT_IN_BITS  = SAMPLE_BITS + 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DELAY    = 3'd0,
      CSR_FEEDBACK = 3'd1,
      CSR_TONE     = 3'd2,
      CSR_WET      = 3'd3,
      CSR_MONO_IN  = 3'd4,
      CSR_MONO_OUT = 3'd5
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic filt;
      logic commit;
   } sfdt_step_type;

   function automatic sample_type sat_sample(input logic signed [SAT_IN_BITS-1:0] v);
      logic signed [SAT_IN_BITS-1:0] hi;
      logic signed [SAT_IN_BITS-1:0] lo;
      hi = {{(SAT_IN_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/sfdt_lane.sv -----
// One channel lane: delay line memory, lowpass feedback filter and wet/dry mix.
`default_nettype none

module sfdt_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sfdt_pkg::sfdt_step_type        step,
   input  wire logic [sfdt_pkg::ADDR_BITS-1:0] rd_addr,
   input  wire logic [sfdt_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire logic                           rd_ok,
   input  wire sfdt_pkg::sample_type           x_in,
   input  wire logic [sfdt_pkg::COEF_BITS-1:0] tone,
   input  wire logic [sfdt_pkg::FB_BITS-1:0]   fb,
   input  wire logic [sfdt_pkg::COEF_BITS-1:0] wet,
   input  wire logic [sfdt_pkg::COEF_BITS-1:0] dry,
   output sfdt_pkg::sample_type                y_out
);
   import sfdt_pkg::*;

   localparam int TONE_W   = LP_BITS + 1 + COEF_BITS + 1;
   localparam int MIX_W    = SAMPLE_BITS + COEF_BITS + 1;
   localparam int FBP_W    = LP_BITS + FB_BITS + 1;
   localparam int FB_SHIFT = 15 + LP_FRAC;

   sample_type line_mem [LINE_DEPTH];

   sample_type                   rdata_ff;
   sample_type                   x_ff;
   logic                         rd_ok_ff;
   logic signed [LP_BITS-1:0]    lp_ff;
   logic signed [TONE_W-1:0]     prod_tone_ff;
   logic signed [MIX_W-1:0]      prod_dry_ff;
   logic signed [MIX_W-1:0]      prod_wet_ff;
   logic signed [FBP_W-1:0]      prod_fb_ff;
   sample_type                   y_ff;

   logic signed [COEF_BITS:0]    tone_s;
   logic signed [COEF_BITS:0]    wet_s;
   logic signed [COEF_BITS:0]    dry_s;
   logic signed [FB_BITS:0]      fb_s;
   sample_type                   d_val;
   logic signed [LP_BITS-1:0]    d_wide;
   logic signed [LP_BITS:0]      diff;
   logic signed [TONE_W-1:0]     tone_rnd;
   logic signed [TONE_W-1:0]     lp_sum;
   logic signed [LP_BITS-1:0]    lp_in;
   logic signed [MIX_W-1:0]      mix_rnd;
   logic signed [FBP_W-1:0]      fb_rnd;
   logic signed [SAT_IN_BITS-1:0] w_sum;
   sample_type                   w_sat;

   assign tone_s = {1'b0, tone};
   assign wet_s  = {1'b0, wet};
   assign dry_s  = {1'b0, dry};
   assign fb_s   = {1'b0, fb};

   always_comb begin
      // an entry the write pointer has not reached yet reads as zero
      d_val    = rd_ok_ff ? rdata_ff : '0;
      d_wide   = LP_BITS'(d_val) <<< LP_FRAC;
      diff     = (LP_BITS+1)'(d_wide) - (LP_BITS+1)'(lp_ff);
      tone_rnd = (prod_tone_ff + TONE_W'(16384)) >>> 15;
      lp_sum   = tone_rnd + TONE_W'(lp_ff);
      lp_in    = lp_sum[LP_BITS-1:0];
      mix_rnd  = (prod_dry_ff + prod_wet_ff + MIX_W'(16384)) >>> 15;
      fb_rnd   = (prod_fb_ff + (FBP_W'(1) <<< (FB_SHIFT-1))) >>> FB_SHIFT;
      w_sum    = SAT_IN_BITS'(x_ff) + fb_rnd[SAT_IN_BITS-1:0];
      w_sat    = sat_sample(w_sum);
   end

   always_ff @(posedge clock) begin
      rdata_ff <= line_mem[rd_addr];
      if (step.commit) begin
         line_mem[wr_addr] <= w_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (step.take) begin
         x_ff     <= x_in;
         rd_ok_ff <= rd_ok;
      end
      if (step.mul) begin
         prod_tone_ff <= diff * tone_s;
         prod_dry_ff  <= x_ff * dry_s;
         prod_wet_ff  <= d_val * wet_s;
      end
      if (step.filt) begin
         prod_fb_ff <= lp_in * fb_s;
         y_ff       <= sat_sample(mix_rnd[SAT_IN_BITS-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= '0;
      end else if (step.filt) begin
         lp_ff <= lp_in;
      end
   end

   assign y_out = y_ff;

endmodule

`default_nettype wire

// ----- design/sfdt_merge.sv -----
// Merge stage: optional mono fold of both lanes and the result output register.
`default_nettype none

module sfdt_merge (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire sfdt_pkg::sample_type y_left,
   input  wire sfdt_pkg::sample_type y_right,
   input  wire logic                 mono_out,
   input  wire logic                 frame_last,
   output logic                      out_free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sfdt_pkg::sample_type      rsp_out_left,
   output sfdt_pkg::sample_type      rsp_out_right,
   output logic                      rsp_frame_end
);
   import sfdt_pkg::*;

   logic                          valid_ff;
   sample_type                    left_ff;
   sample_type                    right_ff;
   logic                          end_ff;
   logic signed [SAT_IN_BITS-1:0] avg_sum;
   sample_type                    avg;

   always_comb begin
      avg_sum = (SAT_IN_BITS'(y_left) + SAT_IN_BITS'(y_right) + SAT_IN_BITS'(1)) >>> 1;
      avg     = sat_sample(avg_sum);
   end

   assign out_free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= mono_out ? avg : y_left;
         right_ff <= mono_out ? avg : y_right;
         end_ff   <= frame_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_left  = left_ff;
   assign rsp_out_right = right_ff;
   assign rsp_frame_end = end_ff;

endmodule

`default_nettype wire

// ----- design/stereo_feedback_delay_tone.sv -----
// Stereo feedback delay top level: registers, frame sequencer, two lanes and merge.
// A result is loaded into the merge output register on the commit step, which follows
// the multiply and filter steps; a frame is accepted only in idle, so a new frame waits
// until commit is done. The commit step waits while the result register still holds an untaken result.
// Reset (synchronous): registers to defaults, write pointer and lowpass to zero.
// Line entries the write pointer has not yet reached read as zero; no clearing pass.
`default_nettype none

module stereo_feedback_delay_tone (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire sfdt_pkg::sample_type               req_in_left,
   input  wire sfdt_pkg::sample_type               req_in_right,
   input  wire logic                               req_frame_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output sfdt_pkg::sample_type                    rsp_out_left,
   output sfdt_pkg::sample_type                    rsp_out_right,
   output logic                                    rsp_frame_end,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sfdt_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [sfdt_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import sfdt_pkg::*;

   localparam int CMP_BITS = (ADDR_BITS > DELAY_BITS ? ADDR_BITS : DELAY_BITS) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FILT,
      ST_COMMIT
   } state_type;

   // configuration registers
   logic [DELAY_BITS-1:0] delay_ff;
   logic [FB_BITS-1:0]    feedback_ff;
   logic [COEF_BITS-1:0]  tone_ff;
   logic [COEF_BITS-1:0]  wet_ff;
   logic                  mono_in_ff;
   logic                  mono_out_ff;

   state_type             state_ff;
   logic [ADDR_BITS-1:0]  write_pos_ff;
   logic                  wrapped_ff;
   logic                  frame_ff;

   sfdt_step_type         step;
   logic                  out_free;
   logic [CMP_BITS-1:0]   dly_wide;
   logic [ADDR_BITS-1:0]  dlen;
   logic [ADDR_BITS:0]    rd_diff;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  rd_ok;
   logic [FB_BITS-1:0]    fb_eff;
   logic [COEF_BITS-1:0]  tone_eff;
   logic [COEF_BITS-1:0]  wet_eff;
   logic [COEF_BITS-1:0]  dry_eff;
   sample_type            x_right;
   sample_type            y_left;
   sample_type            y_right;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= DELAY_BITS'(18720);
         feedback_ff <= FB_BITS'(10895);
         tone_ff     <= COEF_BITS'(23134);
         wet_ff      <= COEF_BITS'(11469);
         mono_in_ff  <= 1'b0;
         mono_out_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DELAY:    delay_ff    <= csr_data[DELAY_BITS-1:0];
            CSR_FEEDBACK: feedback_ff <= csr_data[FB_BITS-1:0];
            CSR_TONE:     tone_ff     <= csr_data[COEF_BITS-1:0];
            CSR_WET:      wet_ff      <= csr_data[COEF_BITS-1:0];
            CSR_MONO_IN:  mono_in_ff  <= csr_data[0];
            CSR_MONO_OUT: mono_out_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fb_eff   = (feedback_ff > FB_BITS'(FB_MAX)) ? FB_BITS'(FB_MAX) : feedback_ff;
      tone_eff = (tone_ff > COEF_BITS'(UNITY)) ? COEF_BITS'(UNITY) : tone_ff;
      wet_eff  = (wet_ff > COEF_BITS'(UNITY)) ? COEF_BITS'(UNITY) : wet_ff;
      dry_eff  = COEF_BITS'(UNITY) - wet_eff;
   end

   // delay clamp and read address, wrapped modulo the line depth
   always_comb begin
      dly_wide = CMP_BITS'(delay_ff);
      if (dly_wide == '0) begin
         dly_wide = CMP_BITS'(1);
      end else if (dly_wide > CMP_BITS'(LINE_DEPTH-1)) begin
         dly_wide = CMP_BITS'(LINE_DEPTH-1);
      end
      dlen    = dly_wide[ADDR_BITS-1:0];
      rd_diff = {1'b0, write_pos_ff} - {1'b0, dlen};
      if (rd_diff[ADDR_BITS]) begin
         rd_addr = rd_diff[ADDR_BITS-1:0] + ADDR_BITS'(LINE_DEPTH);
      end else begin
         rd_addr = rd_diff[ADDR_BITS-1:0];
      end
      // before the first wrap only addresses below the pointer hold data
      rd_ok = wrapped_ff || !rd_diff[ADDR_BITS];
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign step.take   = req_valid && (state_ff == ST_IDLE);
   assign step.mul    = (state_ff == ST_MUL);
   assign step.filt   = (state_ff == ST_FILT);
   assign step.commit = (state_ff == ST_COMMIT) && out_free;

   assign x_right = mono_in_ff ? req_in_left : req_in_right;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         write_pos_ff <= '0;
         wrapped_ff   <= 1'b0;
         frame_ff     <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (step.take) begin
                  frame_ff <= req_frame_last;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:  state_ff <= ST_FILT;
            ST_FILT: state_ff <= ST_COMMIT;
            ST_COMMIT: begin
               if (step.commit) begin
                  if (write_pos_ff == ADDR_BITS'(LINE_DEPTH-1)) begin
                     write_pos_ff <= '0;
                     wrapped_ff   <= 1'b1;
                  end else begin
                     write_pos_ff <= write_pos_ff + ADDR_BITS'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   sfdt_lane u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rd_addr (rd_addr),
      .wr_addr (write_pos_ff),
      .rd_ok   (rd_ok),
      .x_in    (req_in_left),
      .tone    (tone_eff),
      .fb      (fb_eff),
      .wet     (wet_eff),
      .dry     (dry_eff),
      .y_out   (y_left)
   );

   sfdt_lane u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rd_addr (rd_addr),
      .wr_addr (write_pos_ff),
      .rd_ok   (rd_ok),
      .x_in    (x_right),
      .tone    (tone_eff),
      .fb      (fb_eff),
      .wet     (wet_eff),
      .dry     (dry_eff),
      .y_out   (y_right)
   );

   sfdt_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (step.commit),
      .y_left        (y_left),
      .y_right       (y_right),
      .mono_out      (mono_out_ff),
      .frame_last    (frame_ff),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .rsp_frame_end (rsp_frame_end)
   );

`ifndef SYNTHESIS
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      step.take |=> (state_ff == ST_MUL))
      else $error("accepted transaction did not start the lane sequence");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      step.commit |=> rsp_valid)
      else $error("commit did not load the result register");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      write_pos_ff <= ADDR_BITS'(LINE_DEPTH-1))
      else $error("write pointer beyond line depth");

   a_rd_not_wr: assert property (@(posedge clock) disable iff (reset)
      step.take |-> (rd_addr != write_pos_ff))
      else $error("read address collides with write address");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrap flag cleared without reset");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the stereo feedback delay with lowpass feedback.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfdt_pkg::*;

   // indexes past the last register, written to check that they are ignored
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_6 = CSR_IDX_BITS'(6);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_7 = CSR_IDX_BITS'(7);

   typedef struct packed {
      sample_type left;
      sample_type right;
      logic       last;
   } echo_result_type;

   localparam sample_type S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   sample_type               req_in_left;
   sample_type               req_in_right;
   logic                     req_frame_last;
   logic                     rsp_valid;
   logic                     rsp_ready;
   sample_type               rsp_out_left;
   sample_type               rsp_out_right;
   logic                     rsp_frame_end;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   stereo_feedback_delay_tone dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_left    (req_in_left),
      .req_in_right   (req_in_right),
      .req_frame_last (req_frame_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_left   (rsp_out_left),
      .rsp_out_right  (rsp_out_right),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // shadow of the block: delay lines, lowpass state, write pointer, registers
   bit signed [SAMPLE_BITS-1:0] echo_line [2][LINE_DEPTH];
   longint                      echo_lp [2];
   int unsigned                 echo_wr_ptr = 0;
   logic [DELAY_BITS-1:0]       echo_delay = 18720;
   logic [FB_BITS-1:0]          echo_fb = 10895;
   logic [COEF_BITS-1:0]        echo_tone = 23134;
   logic [COEF_BITS-1:0]        echo_wet = 11469;
   logic                        echo_mono_in = 1'b0;
   logic                        echo_mono_out = 1'b0;

   echo_result_type pending_frames[$];
   int           error_count = 0;
   int           frames_checked = 0;
   int           csr_writes = 0;
   bit           feed_steady = 0;
   bit           drain_steady = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** stereo_feedback_delay_tone: FAILED **");
      $finish;
   end

   // add half, then floor
   function automatic longint round_half_up(input longint x, input int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_sample(input longint x);
      longint hi;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   task automatic apply_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_DELAY:    echo_delay = data[DELAY_BITS-1:0];
         CSR_FEEDBACK: echo_fb = data[FB_BITS-1:0];
         CSR_TONE:     echo_tone = data[COEF_BITS-1:0];
         CSR_WET:      echo_wet = data[COEF_BITS-1:0];
         CSR_MONO_IN:  echo_mono_in = data[0];
         CSR_MONO_OUT: echo_mono_out = data[0];
         default: begin
         end
      endcase
   endtask

   task automatic compute_echo_frame(input sample_type in_l, input sample_type in_r,
                                     input logic last);
      longint       x [2];
      longint       y [2];
      longint       fb, tone, wet, dry, d, diff;
      int unsigned  dly, rd;
      int           ch;
      echo_result_type r;
      fb = (echo_fb > FB_MAX) ? FB_MAX : echo_fb;
      tone = (echo_tone > UNITY) ? UNITY : echo_tone;
      wet = (echo_wet > UNITY) ? UNITY : echo_wet;
      dry = UNITY - wet;
      x[0] = in_l;
      x[1] = echo_mono_in ? in_l : in_r;
      dly = echo_delay;
      if (dly == 0) dly = 1;
      if (dly > LINE_DEPTH - 1) dly = LINE_DEPTH - 1;
      rd = (echo_wr_ptr + LINE_DEPTH - dly) % LINE_DEPTH;
      for (ch = 0; ch < 2; ch++) begin
         d = echo_line[ch][rd];
         diff = (d <<< LP_FRAC) - echo_lp[ch];
         echo_lp[ch] += round_half_up(diff * tone, 15);
         echo_line[ch][echo_wr_ptr] = SAMPLE_BITS'(
            clamp_sample(x[ch] + round_half_up(echo_lp[ch] * fb, 15 + LP_FRAC)));
         y[ch] = clamp_sample(round_half_up(x[ch] * dry + d * wet, 15));
      end
      echo_wr_ptr = (echo_wr_ptr + 1) % LINE_DEPTH;
      if (echo_mono_out) begin
         y[0] = clamp_sample(round_half_up(y[0] + y[1], 1));
         y[1] = y[0];
      end
      r.left = y[0][SAMPLE_BITS-1:0];
      r.right = y[1][SAMPLE_BITS-1:0];
      r.last = last;
      pending_frames.push_back(r);
   endtask

   // valid is left high after a transaction so a zero gap keeps it asserted
   task automatic send_frame(input sample_type l, input sample_type r, input logic last);
      int gap;
      gap = feed_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_left <= l;
      req_in_right <= r;
      req_frame_last <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      compute_echo_frame(l, r, last);
   endtask

   task automatic req_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending, then let every pending frame come back and the pipe settle
   task automatic quiesce();
      req_idle();
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      apply_csr(idx, data);
      csr_writes++;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 5))
         0: return S_MAX;
         1: return S_MIN;
         2: return sample_type'($urandom_range(0, 2000)) - sample_type'(1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic random_config();
      logic [CSR_DATA_BITS-1:0] v;
      case ($urandom_range(0, 7))
         0: v = 0;
         1: v = 262143;
         2: v = CSR_DATA_BITS'($urandom_range(300, 262143));
         3: v = CSR_DATA_BITS'($urandom_range(17, 300));
         default: v = CSR_DATA_BITS'($urandom_range(1, 16));
      endcase
      csr_write(CSR_DELAY, v);
      case ($urandom_range(0, 3))
         0: v = 0;
         1: v = CSR_DATA_BITS'(FB_MAX);
         2: v = 32767;
         default: v = CSR_DATA_BITS'($urandom_range(0, 32767));
      endcase
      csr_write(CSR_FEEDBACK, v);
      case ($urandom_range(0, 4))
         0: v = 0;
         1: v = 655;
         2: v = CSR_DATA_BITS'(UNITY);
         3: v = 65535;
         default: v = CSR_DATA_BITS'($urandom_range(0, 65535));
      endcase
      csr_write(CSR_TONE, v);
      case ($urandom_range(0, 3))
         0: v = 0;
         1: v = CSR_DATA_BITS'(UNITY);
         2: v = 65535;
         default: v = CSR_DATA_BITS'($urandom_range(0, 65535));
      endcase
      csr_write(CSR_WET, v);
      csr_write(CSR_MONO_IN, CSR_DATA_BITS'($urandom_range(0, 1)));
      csr_write(CSR_MONO_OUT, CSR_DATA_BITS'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7,
                   CSR_DATA_BITS'($urandom));
   endtask

   task automatic test_reset_state();
      send_frame(S_MAX, S_MIN, 1'b0);
      send_frame(S_MIN, S_MAX, 1'b1);
      send_frame('0, '1, 1'b0);
      send_frame(24'sd123456, -24'sd654321, 1'b1);
   endtask

   // zero delay clamps to one; gains above their limits saturate
   task automatic test_hot_feedback();
      quiesce();
      csr_write(CSR_DELAY, 0);
      csr_write(CSR_FEEDBACK, 32767);
      csr_write(CSR_TONE, 65535);
      csr_write(CSR_WET, 65535);
      repeat (3) send_frame(S_MAX, S_MIN, 1'b0);
      repeat (3) send_frame(S_MIN, S_MAX, 1'b1);
   endtask

   task automatic test_dry_path();
      quiesce();
      csr_write(CSR_WET, 0);
      csr_write(CSR_DELAY, 2);
      csr_write(CSR_FEEDBACK, CSR_DATA_BITS'(FB_MAX));
      send_frame(S_MAX, S_MAX, 1'b0);
      send_frame(S_MIN, 24'sd1, 1'b0);
      send_frame(-24'sd1, S_MIN, 1'b1);
   endtask

   // tone of zero holds the lowpass where it is
   task automatic test_tone_freeze();
      quiesce();
      csr_write(CSR_TONE, 0);
      csr_write(CSR_WET, CSR_DATA_BITS'(UNITY));
      csr_write(CSR_DELAY, 1);
      send_frame(S_MAX, S_MIN, 1'b0);
      send_frame(24'sd4242, -24'sd777, 1'b0);
      send_frame(S_MIN, S_MAX, 1'b1);
   endtask

   task automatic test_mono_paths();
      quiesce();
      csr_write(CSR_TONE, 16384);
      csr_write(CSR_WET, 16384);
      csr_write(CSR_MONO_IN, 1);
      csr_write(CSR_SPARE_6, '1);
      csr_write(CSR_SPARE_7, 1);
      send_frame(S_MAX, S_MIN, 1'b0);
      send_frame(-24'sd5000, 24'sd9999, 1'b1);
      quiesce();
      csr_write(CSR_MONO_IN, 0);
      csr_write(CSR_MONO_OUT, 1);
      send_frame(S_MAX, S_MAX, 1'b0);
      send_frame(24'sd3, -24'sd2, 1'b1);
      quiesce();
      csr_write(CSR_MONO_IN, 1);
      send_frame(S_MIN, S_MAX, 1'b0);
      quiesce();
      csr_write(CSR_MONO_IN, 0);
      csr_write(CSR_MONO_OUT, 0);
   endtask

   task automatic test_longest_delay();
      quiesce();
      csr_write(CSR_DELAY, 262143);
      send_frame(S_MAX, S_MIN, 1'b0);
      send_frame(24'sd77, -24'sd77, 1'b1);
   endtask

   task automatic test_random_phases();
      int p;
      int n;
      for (p = 0; p < 10; p++) begin
         quiesce();
         random_config();
         feed_steady = (p == 3 || p == 6);
         drain_steady = (p == 3 || p == 7);
         for (n = 0; n < 50; n++) begin
            if (p == 5 && n == 25) quiesce();
            send_frame(pick_sample(), pick_sample(),
                       ($urandom_range(0, 7) == 0) || n == 49);
         end
      end
      feed_steady = 0;
      drain_steady = 0;
   endtask

   // result side: random stall (none in steady drain phases) before each transaction, then compare
   initial begin : frame_checker
      int           stall;
      echo_result_type want;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = drain_steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_frames.size() == 0) begin
            $error("unexpected frame: out_left %0d out_right %0d frame_end %0b",
                   rsp_out_left, rsp_out_right, rsp_frame_end);
            error_count++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_out_left !== want.left) begin
               $error("out_left: expected %0d, got %0d", want.left, rsp_out_left);
               error_count++;
            end
            if (rsp_out_right !== want.right) begin
               $error("out_right: expected %0d, got %0d", want.right, rsp_out_right);
               error_count++;
            end
            if (rsp_frame_end !== want.last) begin
               $error("frame_end: expected %0b, got %0b", want.last, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_left <= '0;
      req_in_right <= '0;
      req_frame_last <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_hot_feedback();
      test_dry_path();
      test_tone_freeze();
      test_mono_paths();
      test_longest_delay();
      test_random_phases();

      quiesce();
      $display("Checked %0d frames across %0d register writes, with delays from the",
               frames_checked, csr_writes);
      $display("clamped minimum to the longest line, mono and stereo paths, saturating gains.");
      if (error_count == 0) begin
         $display("** stereo_feedback_delay_tone: PASSED **");
      end else begin
         $display("** stereo_feedback_delay_tone: FAILED **");
      end
      $finish;
   end

endmodule
